### rtl/brf_pkg.sv
// Shared types and constants for the byte ring FIFO with tentative writes.
package brf_pkg;

  // Default storage depth and longest granted read
  localparam int DEPTH_DEF    = 4096;
  localparam int MAX_READ_DEF = 64;

  // Fixed field widths
  localparam int LEN_W  = 13;
  localparam int BYTE_W = 8;
  localparam int OP_W   = 3;

  // Size register value after reset
  localparam logic [LEN_W-1:0] BUFFER_SIZE_RST = 13'd4096;

  // Command codes
  localparam logic [OP_W-1:0] OP_WRITE    = 3'd0;
  localparam logic [OP_W-1:0] OP_PREWRITE = 3'd1;
  localparam logic [OP_W-1:0] OP_COMMIT   = 3'd2;
  localparam logic [OP_W-1:0] OP_DISCARD  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ     = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd5;

  // Command item
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [BYTE_W-1:0] data_byte;
    logic              chunk_first;
    logic [LEN_W-1:0]  chunk_length;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              accepted;
    logic [LEN_W-1:0]  committed_count;
    logic [LEN_W-1:0]  free_space;
    logic              last;
  } res_t;

endpackage

### rtl/byte_ring_fifo_with_tentative_write_top.sv
// Byte ring FIFO with committed and tentative write positions, commit and rollback.
//
//   channel  | valid      | stall      | payload            | direction
//   ---------+------------+------------+--------------------+----------
//   command  | cmd_valid  | cmd_stall  | cmd  (brf_pkg::cmd_t) | in
//   result   | res_valid  | res_stall  | res  (brf_pkg::res_t) | out
//   config   | cfg_write  | -          | cfg_data (13 bits) | in
//
// Write, prewrite, commit, discard, clear, unused codes, and empty or over-limit reads
// each give one result. A read of N bytes from 1 to MAX_READ gives N results at one
// per cycle unless the result is stalled; a granted one first waits on the registered read
// port of the ring memory before its results are loaded into the result register.
// No command is taken until the last result is loaded. Reset is synchronous and clears
// all control state; ring contents are kept. A stalled result holds and blocks commands.
module byte_ring_fifo_with_tentative_write_top #(
  parameter int DEPTH    = brf_pkg::DEPTH_DEF,
  parameter int MAX_READ = brf_pkg::MAX_READ_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  brf_pkg::cmd_t              cmd,
  output logic                       res_valid,
  input  logic                       res_stall,
  output brf_pkg::res_t              res,
  input  logic                       cfg_write,
  input  logic [brf_pkg::LEN_W-1:0]  cfg_data
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LEN_W  = brf_pkg::LEN_W;
  localparam int WW     = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
  localparam int EMIT_W = $clog2(MAX_READ + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // Ring storage and its registered read port
  logic [brf_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [brf_pkg::BYTE_W-1:0] ram_q;

  // Control state
  logic                  state;
  logic [LEN_W-1:0]      buffer_size;
  logic [IDX_W-1:0]      ridx, cidx, tidx;
  logic [CNT_W-1:0]      cc, tc;
  logic [LEN_W-1:0]      left;
  logic                  granted;
  logic                  rd_refused;
  logic                  rd_pend;
  logic [EMIT_W-1:0]     issue_left, emit_left;

  logic [WW-1:0] eff;
  logic [WW-1:0] bs_w;

  // Effective ring size: zero counts as one, clamp at the depth
  always_comb begin
    bs_w = WW'(buffer_size);
    if (buffer_size == '0) begin
      eff = WW'(1);
    end else if (bs_w > WW'(DEPTH)) begin
      eff = WW'(DEPTH);
    end else begin
      eff = bs_w;
    end
  end

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                 input logic [WW-1:0] size);
    logic [WW-1:0] n;
    n = WW'(i) + WW'(1);
    return (n >= size) ? '0 : n[IDX_W-1:0];
  endfunction

  function automatic logic [WW-1:0] space_of(input logic [CNT_W-1:0] count,
                                             input logic [WW-1:0] size);
    logic [WW-1:0] c;
    c = WW'(count);
    return (c >= size) ? '0 : size - c;
  endfunction

  logic slot_free;
  logic cmd_fire;

  assign slot_free = !res_valid || !res_stall;
  assign cmd_stall = (state != ST_IDLE) || !slot_free;
  assign cmd_fire  = cmd_valid && !cmd_stall;

  // Next state for one accepted command
  logic [IDX_W-1:0]           n_ridx, n_cidx, n_tidx;
  logic [CNT_W-1:0]           n_cc, n_tc;
  logic [LEN_W-1:0]           n_left;
  logic                       n_granted;
  logic                       acc;
  logic                       single;
  logic                       go_read;
  logic                       rd_ok;
  logic                       do_store;
  logic                       plain;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [WW-1:0]              len_w;
  logic [WW-1:0]              room;
  logic [CNT_W-1:0]           rd_len;

  always_comb begin
    n_ridx    = ridx;
    n_cidx    = cidx;
    n_tidx    = tidx;
    n_cc      = cc;
    n_tc      = tc;
    n_left    = left;
    n_granted = granted;
    acc       = 1'b0;
    single    = 1'b1;
    go_read   = 1'b0;
    rd_ok     = 1'b0;
    do_store  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = cidx;
    len_w     = WW'(cmd.chunk_length);
    plain     = (cmd.opcode == brf_pkg::OP_WRITE);
    room      = space_of(plain ? cc : tc, eff);
    rd_len    = CNT_W'(cmd.chunk_length);

    unique case (cmd.opcode) inside
      brf_pkg::OP_WRITE, brf_pkg::OP_PREWRITE: begin
        if (cmd.chunk_first) begin
          // Grant or refuse the whole chunk against free space
          if (len_w <= room) begin
            n_granted = 1'b1;
            n_left    = cmd.chunk_length;
            acc       = 1'b1;
            if (plain) begin
              n_tidx = cidx;
              n_tc   = cc;
            end
            do_store = (cmd.chunk_length != '0);
          end else begin
            n_granted = 1'b0;
            n_left    = '0;
          end
        end else begin
          do_store = granted && (left != '0);
        end
        // Store one byte at the committed or tentative position
        if (do_store) begin
          if (plain ? (WW'(n_cc) < eff) : (WW'(n_tc) < eff)) begin
            wr_en = 1'b1;
            if (plain) begin
              wr_addr = n_cidx;
              n_cidx  = next_idx(n_cidx, eff);
              n_cc    = n_cc + CNT_W'(1);
              n_tidx  = n_cidx;
              n_tc    = n_cc;
            end else begin
              wr_addr = n_tidx;
              n_tidx  = next_idx(n_tidx, eff);
              n_tc    = n_tc + CNT_W'(1);
            end
            n_left = n_left - LEN_W'(1);
            acc    = 1'b1;
          end else begin
            n_granted = 1'b0;
            n_left    = '0;
            acc       = 1'b0;
          end
        end
      end
      brf_pkg::OP_COMMIT: begin
        n_granted = 1'b0;
        n_left    = '0;
        n_cc      = tc;
        n_cidx    = tidx;
        acc       = 1'b1;
      end
      brf_pkg::OP_DISCARD: begin
        n_granted = 1'b0;
        n_left    = '0;
        n_tc      = cc;
        n_tidx    = cidx;
        acc       = 1'b1;
      end
      brf_pkg::OP_CLEAR: begin
        n_granted = 1'b0;
        n_left    = '0;
        n_ridx    = '0;
        n_cidx    = '0;
        n_tidx    = '0;
        n_cc      = '0;
        n_tc      = '0;
        acc       = 1'b1;
      end
      brf_pkg::OP_READ: begin
        // Wrap a read position left beyond a smaller size
        if (WW'(ridx) >= eff) begin
          n_ridx = '0;
        end
        if (cmd.chunk_length == '0) begin
          acc = 1'b1;
        end else if (len_w > WW'(MAX_READ)) begin
          acc = 1'b0;
        end else begin
          single  = 1'b0;
          go_read = 1'b1;
          if (WW'(cc) >= len_w) begin
            rd_ok = 1'b1;
            n_cc  = cc - rd_len;
            n_tc  = tc - rd_len;
          end
        end
      end
      default: begin
        acc = 1'b0;
      end
    endcase
  end

  // Read stream: issue addresses and move read data to the result register
  logic stream_move;
  logic issue;

  assign stream_move = (state == ST_READ) && slot_free &&
                       (rd_refused ? (emit_left != '0) : rd_pend);
  assign issue       = (state == ST_READ) && !rd_refused && (issue_left != '0) &&
                       (!rd_pend || stream_move);

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd_fire && wr_en) begin
      mem[wr_addr] <= cmd.data_byte;
    end
    if (issue) begin
      ram_q <= mem[ridx];
    end
  end

  // Size register
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= brf_pkg::BUFFER_SIZE_RST;
    end else if (cfg_write) begin
      buffer_size <= cfg_data;
    end
  end

  // Pointers, counts, chunk state and read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ridx       <= '0;
      cidx       <= '0;
      tidx       <= '0;
      cc         <= '0;
      tc         <= '0;
      left       <= '0;
      granted    <= 1'b0;
      rd_refused <= 1'b0;
      rd_pend    <= 1'b0;
      issue_left <= '0;
      emit_left  <= '0;
    end else begin
      if (cmd_fire) begin
        ridx    <= n_ridx;
        cidx    <= n_cidx;
        tidx    <= n_tidx;
        cc      <= n_cc;
        tc      <= n_tc;
        left    <= n_left;
        granted <= n_granted;
        if (go_read) begin
          state      <= ST_READ;
          rd_refused <= !rd_ok;
          issue_left <= rd_ok ? EMIT_W'(cmd.chunk_length) : '0;
          emit_left  <= EMIT_W'(cmd.chunk_length);
        end
      end
      if (issue) begin
        ridx       <= next_idx(ridx, eff);
        issue_left <= issue_left - EMIT_W'(1);
      end
      if (issue) begin
        rd_pend <= 1'b1;
      end else if (stream_move) begin
        rd_pend <= 1'b0;
      end
      if (stream_move) begin
        emit_left <= emit_left - EMIT_W'(1);
        if (emit_left == EMIT_W'(1)) begin
          state <= ST_IDLE;
        end
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((cmd_fire && single) || stream_move) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (cmd_fire && single) begin
      res.read_byte       <= '0;
      res.accepted        <= acc;
      res.committed_count <= LEN_W'(n_cc);
      res.free_space      <= LEN_W'(space_of(n_cc, eff));
      res.last            <= 1'b1;
    end else if (stream_move) begin
      res.read_byte       <= rd_refused ? '0 : ram_q;
      res.accepted        <= !rd_refused;
      res.committed_count <= LEN_W'(cc);
      res.free_space      <= LEN_W'(space_of(cc, eff));
      res.last            <= (emit_left == EMIT_W'(1));
    end
  end

endmodule

### rtl/brf_checker.sv
// Port-level checker for the byte ring FIFO, bound to the top level.
module brf_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_stall,
  input logic          res_valid,
  input logic          res_stall,
  input brf_pkg::res_t res
);

  // Clear the result register on reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // Block commands while a read still has results to give
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |-> cmd_stall)
    else $error("command taken in the middle of a read");

  // Give zero bytes on refused items
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.accepted |-> res.read_byte == '0)
    else $error("refused item carries a byte");

endmodule

bind byte_ring_fifo_with_tentative_write_top brf_checker u_brf_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

### bench/tb_byte_ring_fifo_with_tentative_write_top.sv
// Self-checking bench for the byte ring FIFO with tentative writes, commit and rollback.
`timescale 1ns / 1ps

module tb_byte_ring_fifo_with_tentative_write_top;
  import brf_pkg::*;

  // Opcodes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int ITEMS_PER_PHASE = 22;
  localparam int NUM_PHASES      = 9;

  // Shadow of the ring: pointers, counts, open chunk and the queue of results owed
  class ring_fifo_scoreboard;
    bit [7:0]   ring_mem [DEPTH_DEF];
    bit [11:0]  rd_ptr;
    bit [11:0]  cm_ptr;
    bit [11:0]  tn_ptr;
    bit [12:0]  cm_cnt;
    bit [12:0]  tn_cnt;
    bit [12:0]  chunk_left;
    bit         chunk_ok;
    bit [12:0]  size_reg;
    res_t       pending_results [$];
    int         errors;

    function new();
      rd_ptr     = '0;
      cm_ptr     = '0;
      tn_ptr     = '0;
      cm_cnt     = '0;
      tn_cnt     = '0;
      chunk_left = '0;
      chunk_ok   = 1'b0;
      size_reg   = BUFFER_SIZE_RST;
      errors     = 0;
    endfunction

    function int eff_size();
      if (size_reg == 0) return 1;
      if (size_reg > DEPTH_DEF) return DEPTH_DEF;
      return int'(size_reg);
    endfunction

    function bit [11:0] step_ptr(bit [11:0] p);
      int n;
      n = p + 1;
      return (n >= eff_size()) ? 12'd0 : n[11:0];
    endfunction

    // Free space against a count, saturating at zero
    function bit [12:0] room(bit [12:0] c);
      int s;
      bit [12:0] r;
      s = eff_size();
      r = (c >= s) ? 13'd0 : 13'(s - c);
      return r;
    endfunction

    function void push_result(bit [7:0] b, bit acc, bit fin);
      res_t r;
      r.read_byte       = b;
      r.accepted        = acc;
      r.committed_count = cm_cnt;
      r.free_space      = room(cm_cnt);
      r.last            = fin;
      pending_results.push_back(r);
    endfunction

    // Store one chunk byte at the committed or the tentative position
    function bit store_byte(bit plain, bit [7:0] b);
      if (plain) begin
        if (cm_cnt >= eff_size()) return 1'b0;
        ring_mem[cm_ptr] = b;
        cm_ptr = step_ptr(cm_ptr);
        cm_cnt++;
        tn_ptr = cm_ptr;
        tn_cnt = cm_cnt;
      end else begin
        if (tn_cnt >= eff_size()) return 1'b0;
        ring_mem[tn_ptr] = b;
        tn_ptr = step_ptr(tn_ptr);
        tn_cnt++;
      end
      return 1'b1;
    endfunction

    // Advance the shadow by one accepted command item and queue its results
    function void take_cmd(cmd_t c);
      bit       plain;
      bit       acc;
      int       len;
      int       k;
      bit [7:0] got [MAX_READ_DEF];
      len = int'(c.chunk_length);
      acc = 1'b0;
      case (c.opcode)
        OP_WRITE, OP_PREWRITE: begin
          plain = (c.opcode == OP_WRITE);
          if (c.chunk_first) begin
            chunk_ok   = (c.chunk_length <= room(plain ? cm_cnt : tn_cnt));
            chunk_left = chunk_ok ? c.chunk_length : 13'd0;
            if (chunk_ok) begin
              if (plain) begin
                tn_ptr = cm_ptr;
                tn_cnt = cm_cnt;
              end
              acc = 1'b1;
              if (chunk_left > 0) begin
                if (store_byte(plain, c.data_byte)) begin
                  chunk_left--;
                end else begin
                  chunk_ok   = 1'b0;
                  chunk_left = '0;
                  acc        = 1'b0;
                end
              end
            end
          end else if (chunk_ok && chunk_left > 0) begin
            if (store_byte(plain, c.data_byte)) begin
              chunk_left--;
              acc = 1'b1;
            end else begin
              chunk_ok   = 1'b0;
              chunk_left = '0;
            end
          end
          push_result(8'd0, acc, 1'b1);
        end
        OP_COMMIT, OP_DISCARD, OP_CLEAR: begin
          chunk_ok   = 1'b0;
          chunk_left = '0;
          if (c.opcode == OP_COMMIT) begin
            cm_cnt = tn_cnt;
            cm_ptr = tn_ptr;
          end else if (c.opcode == OP_DISCARD) begin
            tn_cnt = cm_cnt;
            tn_ptr = cm_ptr;
          end else begin
            rd_ptr = '0;
            cm_ptr = '0;
            tn_ptr = '0;
            cm_cnt = '0;
            tn_cnt = '0;
          end
          push_result(8'd0, 1'b1, 1'b1);
        end
        OP_READ: begin
          if (rd_ptr >= eff_size()) rd_ptr = '0;
          if (len == 0) begin
            push_result(8'd0, 1'b1, 1'b1);
          end else if (len > MAX_READ_DEF) begin
            push_result(8'd0, 1'b0, 1'b1);
          end else if (cm_cnt < len) begin
            for (k = 0; k < len; k++) push_result(8'd0, 1'b0, k == len - 1);
          end else begin
            for (k = 0; k < len; k++) begin
              got[k] = ring_mem[rd_ptr];
              rd_ptr = step_ptr(rd_ptr);
            end
            cm_cnt = cm_cnt - 13'(len);
            tn_cnt = tn_cnt - 13'(len);
            for (k = 0; k < len; k++) push_result(got[k], 1'b1, k == len - 1);
          end
        end
        default: begin
          push_result(8'd0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void report_field(string name, logic [12:0] want, logic [12:0] seen);
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
    endfunction

    // Compare one accepted result item with the oldest one owed
    function void check_res(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result expected none, got %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got.read_byte !== want.read_byte)
          report_field("read_byte", 13'(want.read_byte), 13'(got.read_byte));
        if (got.accepted !== want.accepted)
          report_field("accepted", 13'(want.accepted), 13'(got.accepted));
        if (got.committed_count !== want.committed_count)
          report_field("committed_count", want.committed_count, got.committed_count);
        if (got.free_space !== want.free_space)
          report_field("free_space", want.free_space, got.free_space);
        if (got.last !== want.last)
          report_field("last", 13'(want.last), 13'(got.last));
      end
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_stall;
  cmd_t              cmd       = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  res_t              res;
  logic              cfg_write = 1'b0;
  logic [LEN_W-1:0]  cfg_data  = '0;

  ring_fifo_scoreboard sb;
  int          tx_idle_pct   = 0;
  int          rx_idle_pct   = 0;
  bit          hold_off_req  = 1'b0;
  int          items_sent    = 0;
  int unsigned cycle_count   = 0;
  int unsigned phase_size [NUM_PHASES] = '{4096, 1, 100, 0, 8191, 64, 5, 23, 4096};

  byte_ring_fifo_with_tentative_write_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_byte_ring_fifo_with_tentative_write_top failed");
      $finish;
    end
  end

  // Note accepted command items first, then check accepted result items
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_stall === 1'b0) sb.take_cmd(cmd);
      if (res_valid === 1'b1 && res_stall === 1'b0) sb.check_res(res);
    end
  end

  // Stall the result side in random bursts, or hold off for a long stretch on request
  initial begin : result_pacer
    int n;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
      end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        n = $urandom_range(1, 9);
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  function automatic cmd_t mk_cmd(logic [OP_W-1:0] op, logic [7:0] b, logic first,
                                  logic [LEN_W-1:0] len);
    cmd_t c;
    c.opcode       = op;
    c.data_byte    = b;
    c.chunk_first  = first;
    c.chunk_length = len;
    return c;
  endfunction

  // Offer one command item after an optional idle burst; return once it is taken
  task automatic send_cmd(cmd_t c);
    int gap;
    gap = 0;
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall !== 1'b0);
    items_sent++;
  endtask

  // Send a chunk head with its length, then count-1 further bytes
  task automatic send_bytes(logic [OP_W-1:0] op, int len, int count, int mix_pct);
    int k;
    logic [OP_W-1:0] cur;
    cur = op;
    send_cmd(mk_cmd(op, 8'($urandom_range(0, 255)), 1'b1, len[12:0]));
    for (k = 1; k < count; k++) begin
      if ($urandom_range(0, 99) < mix_pct) cur = (cur == OP_WRITE) ? OP_PREWRITE : OP_WRITE;
      send_cmd(mk_cmd(cur, 8'($urandom_range(0, 255)), 1'b0,
                      LEN_W'($urandom_range(0, 8191))));
    end
  endtask

  // Drop valid and wait until every owed result has arrived
  task automatic drain_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the size register while idle, optionally wiping the ring afterwards
  task automatic set_size(logic [LEN_W-1:0] value, bit wipe);
    drain_results();
    cfg_data  <= value;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.size_reg = value;
    if (wipe) send_cmd(mk_cmd(OP_CLEAR, 8'd0, 1'b0, 13'd0));
  endtask

  // One random sequence: mostly well-formed chunks and reads, some noise
  task automatic random_step();
    int pick;
    int room_now;
    int len;
    int nbytes;
    int k;
    int cnt;
    logic [OP_W-1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      op = (pick < 35) ? OP_WRITE : OP_PREWRITE;
      room_now = int'(sb.room(op == OP_WRITE ? sb.cm_cnt : sb.tn_cnt));
      k = $urandom_range(0, 9);
      if (k < 7) len = $urandom_range(0, room_now < 10 ? room_now : 10);
      else if (k < 9) len = room_now + $urandom_range(1, 3);
      else len = $urandom_range(0, 8191);
      nbytes = (len < 10) ? len : $urandom_range(1, 4);
      if (nbytes == 0) nbytes = 1;
      if ($urandom_range(0, 5) == 0) nbytes++;
      send_bytes(op, len, nbytes, 10);
      if (op == OP_PREWRITE) begin
        k = $urandom_range(0, 9);
        if (k < 5) send_cmd(mk_cmd(OP_COMMIT, 8'($urandom_range(0, 255)), 1'b0, 13'd0));
        else if (k < 8) send_cmd(mk_cmd(OP_DISCARD, 8'($urandom_range(0, 255)), 1'b0, 13'd0));
      end
    end else if (pick < 80) begin
      cnt = int'(sb.cm_cnt);
      k = $urandom_range(0, 9);
      if (k < 6 && cnt > 0) len = $urandom_range(1, cnt < MAX_READ_DEF ? cnt : MAX_READ_DEF);
      else if (k < 8) len = cnt + $urandom_range(1, 4);
      else if (k < 9) len = 0;
      else len = $urandom_range(MAX_READ_DEF + 1, 8191);
      send_cmd(mk_cmd(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      len[12:0]));
    end else if (pick < 85) begin
      send_cmd(mk_cmd(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      LEN_W'($urandom_range(0, 8191))));
    end else if (pick < 90) begin
      op = $urandom_range(0, 1) ? OP_COMMIT : OP_DISCARD;
      send_cmd(mk_cmd(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      LEN_W'($urandom_range(0, 8191))));
    end else begin
      send_cmd(mk_cmd(OP_W'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), LEN_W'($urandom_range(0, 8191))));
    end
  endtask

  initial begin : stimulus
    int p;
    int target;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on a 17-byte ring
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    set_size(13'd17, 1'b1);
    send_cmd(mk_cmd(OP_READ, 8'h00, 1'b0, 13'd0));       // empty read is granted
    send_cmd(mk_cmd(OP_READ, 8'h00, 1'b0, 13'd5));       // not enough data: five refusals
    send_cmd(mk_cmd(OP_READ, 8'h00, 1'b0, 13'd65));      // over the read limit
    send_cmd(mk_cmd(OP_READ, 8'hFF, 1'b1, 13'h1FFF));
    send_cmd(mk_cmd(OP_WRITE, 8'hFF, 1'b1, 13'd0));      // zero-length chunk
    send_cmd(mk_cmd(OP_WRITE, 8'h00, 1'b1, 13'd3));
    send_cmd(mk_cmd(OP_WRITE, 8'hFF, 1'b0, 13'h1FFF));
    send_cmd(mk_cmd(OP_PREWRITE, 8'h5A, 1'b0, 13'd0));   // byte opcode decides: tentative
    send_cmd(mk_cmd(OP_READ, 8'h00, 1'b0, 13'd2));
    send_bytes(OP_PREWRITE, 2, 2, 0);
    send_cmd(mk_cmd(OP_READ, 8'h00, 1'b0, 13'd1));       // tentative bytes stay hidden
    send_cmd(mk_cmd(OP_COMMIT, 8'h00, 1'b0, 13'd0));
    send_bytes(OP_PREWRITE, 3, 3, 0);
    send_cmd(mk_cmd(OP_DISCARD, 8'h00, 1'b0, 13'd0));
    send_bytes(OP_WRITE, 16, 2, 0);                      // chunk larger than free space
    send_bytes(OP_PREWRITE, 1, 1, 0);
    send_bytes(OP_WRITE, 1, 1, 0);                       // plain write cancels the prewrite
    send_cmd(mk_cmd(OP_COMMIT, 8'h00, 1'b0, 13'd0));
    send_bytes(OP_WRITE, 2, 3, 0);                       // byte past the chunk end
    send_bytes(OP_WRITE, 4, 2, 0);
    send_cmd(mk_cmd(OP_COMMIT, 8'h00, 1'b0, 13'd0));
    send_cmd(mk_cmd(OP_WRITE, 8'h11, 1'b0, 13'd0));      // chunk closed by commit
    send_cmd(mk_cmd(OP_SPARE6, 8'hFF, 1'b1, 13'h1FFF));
    send_cmd(mk_cmd(OP_SPARE7, 8'h00, 1'b0, 13'd0));
    send_cmd(mk_cmd(OP_READ, 8'h00, 1'b0, 13'd2));
    send_cmd(mk_cmd(OP_CLEAR, 8'h00, 1'b0, 13'd0));

    // Shrink the ring under held data: counts beyond size, read pointer wraps home
    send_bytes(OP_WRITE, 5, 5, 0);
    send_cmd(mk_cmd(OP_READ, 8'h00, 1'b0, 13'd2));
    send_bytes(OP_WRITE, 4, 2, 0);
    set_size(13'd2, 1'b0);
    send_cmd(mk_cmd(OP_WRITE, 8'h77, 1'b0, 13'd0));      // open chunk hits the full count
    send_cmd(mk_cmd(OP_READ, 8'h00, 1'b0, 13'd2));
    send_bytes(OP_PREWRITE, 1, 1, 0);
    send_cmd(mk_cmd(OP_READ, 8'h00, 1'b0, 13'd3));

    // Random phases over several ring sizes, the last one without idling
    target = items_sent;
    for (p = 0; p < NUM_PHASES; p++) begin
      set_size(LEN_W'(phase_size[p]), 1'b1);
      if (p == NUM_PHASES - 1) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = (p % 3 == 1) ? 0 : $urandom_range(10, 45);
        rx_idle_pct = (p % 3 == 2) ? 0 : $urandom_range(10, 45);
      end
      if (p == 2) hold_off_req = 1'b1;
      target = target + ITEMS_PER_PHASE;
      while (items_sent < target) random_step();
    end

    drain_results();
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("tb_byte_ring_fifo_with_tentative_write_top passed");
    end else begin
      $display("tb_byte_ring_fifo_with_tentative_write_top failed");
    end
    $finish;
  end

endmodule
